// ===== design/ciddp_pkg.sv =====
// shared types and constants for the copy/insert delta parser
`default_nettype none
package ciddp_pkg;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   localparam logic [1:0] KIND_LITERAL = 2'd0;
   localparam logic [1:0] KIND_COPY    = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [1:0] FAULT_NONE   = 2'd0;
   localparam logic [1:0] FAULT_TRUNC  = 2'd1;
   localparam logic [1:0] FAULT_BADOP  = 2'd2;
   localparam logic [1:0] FAULT_RANGE  = 2'd3;

   localparam logic [7:0] OP_COPY      = 8'd0;
   localparam logic [7:0] OP_INSERT    = 8'd1;

   // csr byte address of the reference length register
   localparam logic [2:0] REG_REFERENCE_LENGTH = 3'd0;

   // one classified result waiting for the back end
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;    // literal byte, or fault code in the low bits
      logic [31:0] start;
      logic [31:0] count;
      logic        fin;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage
`default_nettype wire

// ===== design/ciddp_front.sv =====
// front end: accepts patch bytes and parses commands into queue entries
`default_nettype none
module ciddp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_patch_byte,
   input  wire logic                 req_final_byte,
   input  wire logic [31:0]          reference_length,
   input  wire ciddp_pkg::qstat_type q_status,
   output logic                      push,
   output ciddp_pkg::entry_type      push_entry
);
   import ciddp_pkg::*;

   localparam logic [2:0] PH_OP       = 3'd0;
   localparam logic [2:0] PH_COPY_OFS = 3'd1;
   localparam logic [2:0] PH_COPY_LEN = 3'd2;
   localparam logic [2:0] PH_INS_LEN  = 3'd3;
   localparam logic [2:0] PH_INS_DATA = 3'd4;
   localparam logic [2:0] PH_DISCARD  = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] ofs_ff, ofs_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] rem_ff, rem_in;
   logic [1:0]  fault_ff, fault_in;

   logic        accept;
   logic [31:0] lane;
   logic [31:0] len_new;
   logic [31:0] rem_dec;
   logic [32:0] copy_end;
   logic        last_hdr;
   logic        res;
   entry_type   ent;

   assign req_stall = q_status.full;
   assign accept    = req_valid & ~q_status.full;

   assign lane     = 32'(req_patch_byte) << {idx_ff, 3'b000};
   assign len_new  = len_ff | lane;
   assign rem_dec  = rem_ff - 32'd1;
   assign last_hdr = (idx_ff == 2'd3);
   assign copy_end = {1'b0, ofs_ff} + {1'b0, len_new};

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      ofs_in   = ofs_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      fault_in = fault_ff;
      res      = 1'b0;
      ent      = '0;
      ent.fin  = req_final_byte;
      case (phase_ff)
         PH_COPY_OFS: begin
            ofs_in = ofs_ff | lane;
            idx_in = idx_ff + 2'd1;
            if (last_hdr) phase_in = PH_COPY_LEN;
            if (req_final_byte) begin
               res = 1'b1; ent.kind = KIND_ERROR; ent.data = 8'(FAULT_TRUNC);
            end
         end
         PH_COPY_LEN: begin
            len_in = len_new;
            idx_in = idx_ff + 2'd1;
            if (!last_hdr) begin
               if (req_final_byte) begin
                  res = 1'b1; ent.kind = KIND_ERROR; ent.data = 8'(FAULT_TRUNC);
               end
            end else if (copy_end > {1'b0, reference_length}) begin
               res = 1'b1; ent.kind = KIND_ERROR; ent.data = 8'(FAULT_RANGE);
               phase_in = PH_DISCARD;
               fault_in = FAULT_RANGE;
            end else begin
               res       = 1'b1;
               ent.kind  = KIND_COPY;
               ent.start = ofs_ff;
               ent.count = len_new;
               phase_in  = PH_OP;
               ofs_in    = '0;
               len_in    = '0;
            end
         end
         PH_INS_LEN: begin
            idx_in = idx_ff + 2'd1;
            if (!last_hdr) begin
               len_in = len_new;
               if (req_final_byte) begin
                  res = 1'b1; ent.kind = KIND_ERROR; ent.data = 8'(FAULT_TRUNC);
               end
            end else begin
               rem_in = len_new;
               len_in = '0;
               if (len_new == '0) begin
                  phase_in = PH_OP;
                  // empty insert closing the patch reports status only
                  if (req_final_byte) begin
                     res = 1'b1; ent.kind = KIND_STATUS;
                  end
               end else if (req_final_byte) begin
                  res = 1'b1; ent.kind = KIND_ERROR; ent.data = 8'(FAULT_TRUNC);
               end else begin
                  phase_in = PH_INS_DATA;
               end
            end
         end
         PH_INS_DATA: begin
            rem_in = rem_dec;
            if (rem_dec == '0) phase_in = PH_OP;
            res = 1'b1;
            if (req_final_byte && rem_dec != '0) begin
               ent.kind = KIND_ERROR; ent.data = 8'(FAULT_TRUNC);
            end else begin
               ent.kind = KIND_LITERAL; ent.data = req_patch_byte;
            end
         end
         PH_DISCARD: begin
            if (req_final_byte) begin
               res = 1'b1; ent.kind = KIND_ERROR; ent.data = 8'(fault_ff);
            end
         end
         default: begin
            phase_in = PH_OP;
            if (req_final_byte) begin
               res = 1'b1; ent.kind = KIND_ERROR; ent.data = 8'(FAULT_TRUNC);
            end else begin
               idx_in = '0;
               ofs_in = '0;
               len_in = '0;
               if (req_patch_byte == OP_COPY) begin
                  phase_in = PH_COPY_OFS;
               end else if (req_patch_byte == OP_INSERT) begin
                  phase_in = PH_INS_LEN;
               end else begin
                  res = 1'b1; ent.kind = KIND_ERROR; ent.data = 8'(FAULT_BADOP);
                  phase_in = PH_DISCARD;
                  fault_in = FAULT_BADOP;
               end
            end
         end
      endcase
      // the last byte of a patch always restarts the parser
      if (req_final_byte) begin
         phase_in = PH_OP;
         idx_in   = '0;
         ofs_in   = '0;
         len_in   = '0;
         rem_in   = '0;
         fault_in = FAULT_NONE;
      end
   end

   assign push       = accept & res;
   assign push_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OP;
         idx_ff   <= '0;
         ofs_ff   <= '0;
         len_ff   <= '0;
         rem_ff   <= '0;
         fault_ff <= FAULT_NONE;
      end else if (accept) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         ofs_ff   <= ofs_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
         fault_ff <= fault_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/ciddp_queue.sv =====
// short queue of classified entries between front and back end
`default_nettype none
module ciddp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire ciddp_pkg::entry_type push_entry,
   input  wire logic                 pop,
   output ciddp_pkg::entry_type      head_entry,
   output ciddp_pkg::qstat_type      q_status
);
   import ciddp_pkg::*;

   entry_type        slot_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == (QAW+1)'(QDEPTH));
   assign do_push        = push & ~q_status.full;
   assign do_pop         = pop & ~q_status.empty;
   assign head_entry     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (QAW+1)'(1);
      if (!do_push && do_pop) count_in = count_ff - (QAW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule
`default_nettype wire

// ===== design/ciddp_back.sv =====
// back end: expands queue entries into result fields and holds the output register
`default_nettype none
module ciddp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ciddp_pkg::entry_type head_entry,
   input  wire ciddp_pkg::qstat_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_item_kind,
   output logic [7:0]                rsp_literal_value,
   output logic [31:0]               rsp_copy_start,
   output logic [31:0]               rsp_copy_count,
   output logic [1:0]                rsp_fault_code,
   output logic                      rsp_end_of_patch
);
   import ciddp_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  lit_ff, lit_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] count_ff, count_in;
   logic [1:0]  fault_ff, fault_in;
   logic        eop_ff, eop_in;
   logic        load;

   assign load     = ~valid_ff | ~rsp_stall;
   assign pop      = load & ~q_status.empty;
   assign valid_in = load ? ~q_status.empty : valid_ff;

   // fields that do not belong to the kind read as zero
   always_comb begin
      kind_in  = head_entry.kind;
      lit_in   = (head_entry.kind == KIND_LITERAL) ? head_entry.data : '0;
      start_in = (head_entry.kind == KIND_COPY) ? head_entry.start : '0;
      count_in = (head_entry.kind == KIND_COPY) ? head_entry.count : '0;
      fault_in = (head_entry.kind == KIND_ERROR) ? head_entry.data[1:0] : FAULT_NONE;
      eop_in   = head_entry.fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= kind_in;
         lit_ff   <= lit_in;
         start_ff <= start_in;
         count_ff <= count_in;
         fault_ff <= fault_in;
         eop_ff   <= eop_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_item_kind     = kind_ff;
   assign rsp_literal_value = lit_ff;
   assign rsp_copy_start    = start_ff;
   assign rsp_copy_count    = count_ff;
   assign rsp_fault_code    = fault_ff;
   assign rsp_end_of_patch  = eop_ff;

endmodule
`default_nettype wire

// ===== design/copy_insert_delta_parser_top.sv =====
// top level of the copy/insert delta patch parser
//
//   channel  | direction | handshake            | payload
//   req      | in        | req_valid/req_stall  | patch_byte, final_byte
//   rsp      | out       | rsp_valid/rsp_stall  | item_kind .. end_of_patch
//   csr      | in/out    | apb psel/penable     | reference_length at 0x0
//
// one byte per cycle is accepted while the queue is not full; the front end parses it in the cycle it is accepted
// a result reaches rsp through the queue slot and then the output register
// req_stall rises only when the four-entry queue is full
// reset is synchronous and returns the parser to awaiting an op byte
`default_nettype none
module copy_insert_delta_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_patch_byte,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_item_kind,
   output logic [7:0]       rsp_literal_value,
   output logic [31:0]      rsp_copy_start,
   output logic [31:0]      rsp_copy_count,
   output logic [1:0]       rsp_fault_code,
   output logic             rsp_end_of_patch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import ciddp_pkg::*;

   logic [31:0] ref_len_ff;
   logic        csr_write;
   logic        push;
   logic        pop;
   entry_type   push_entry;
   entry_type   head_entry;
   qstat_type   q_status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & ~csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : ref_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_len_ff <= '0;
      end else if (csr_write) begin
         ref_len_ff <= csr_pwdata;
      end
   end

   ciddp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_patch_byte   (req_patch_byte),
      .req_final_byte   (req_final_byte),
      .reference_length (ref_len_ff),
      .q_status         (q_status),
      .push             (push),
      .push_entry       (push_entry)
   );

   ciddp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   ciddp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_entry        (head_entry),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_literal_value (rsp_literal_value),
      .rsp_copy_start    (rsp_copy_start),
      .rsp_copy_count    (rsp_copy_count),
      .rsp_fault_code    (rsp_fault_code),
      .rsp_end_of_patch  (rsp_end_of_patch)
   );

endmodule
`default_nettype wire

// ===== design/ciddp_checker.sv =====
// port-level checks for the delta parser, bound to the top level
`default_nettype none
module ciddp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_item_kind,
   input wire logic [31:0] rsp_copy_start,
   input wire logic [31:0] rsp_copy_count,
   input wire logic [1:0]  rsp_fault_code,
   input wire logic        rsp_end_of_patch
);
   import ciddp_pkg::*;

   // nothing comes out in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds its contents
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item_kind)
         && $stable(rsp_copy_start) && $stable(rsp_end_of_patch))
      else $error("stalled result changed");

   // status-only results exist only to close a patch
   a_status_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_STATUS |-> rsp_end_of_patch)
      else $error("status result without end of patch");

   // a fault code travels only on error results
   a_fault_only_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind != KIND_ERROR |-> rsp_fault_code == FAULT_NONE)
      else $error("fault code on non-error result");

   // copy fields are clear on anything but a copy
   a_copy_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind != KIND_COPY
         |-> rsp_copy_start == '0 && rsp_copy_count == '0)
      else $error("copy fields set on non-copy result");

endmodule

bind copy_insert_delta_parser_top ciddp_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_item_kind     (rsp_item_kind),
   .rsp_copy_start    (rsp_copy_start),
   .rsp_copy_count    (rsp_copy_count),
   .rsp_fault_code    (rsp_fault_code),
   .rsp_end_of_patch  (rsp_end_of_patch)
);
`default_nettype wire

// ===== bench/ciddp_stream_checker.sv =====
// result checker for the delta parser: predicts from accepted items and compares
`timescale 1ns / 1ps
module ciddp_stream_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_patch_byte,
   input  wire logic        req_final_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [1:0]  rsp_item_kind,
   input  wire logic [7:0]  rsp_literal_value,
   input  wire logic [31:0] rsp_copy_start,
   input  wire logic [31:0] rsp_copy_count,
   input  wire logic [1:0]  rsp_fault_code,
   input  wire logic        rsp_end_of_patch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               fail_count = 0,
   output int               pending = 0
);
   import ciddp_pkg::*;

   typedef enum logic [2:0] {
      PH_AWAIT_OP,
      PH_COPY_OFS,
      PH_COPY_LEN,
      PH_INS_LEN,
      PH_INS_DATA,
      PH_DISCARD
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  lit;
      logic [31:0] start;
      logic [31:0] count;
      logic [1:0]  fault;
      logic        eop;
   } patch_result_type;

   patch_result_type due_results[$];

   parse_phase_type phase = PH_AWAIT_OP;
   logic [1:0]   hdr_idx = '0;
   logic [31:0]  ofs_acc = '0;
   logic [31:0]  len_acc = '0;
   logic [31:0]  ins_left = '0;
   logic [1:0]   held_fault = '0;
   logic [31:0]  ref_len = '0;

   function automatic void restart_parse();
      phase = PH_AWAIT_OP;
      hdr_idx = '0;
      ofs_acc = '0;
      len_acc = '0;
      ins_left = '0;
      held_fault = '0;
   endfunction

   // a result on the last byte of a patch also starts the next patch afresh
   function automatic void post_result(input logic [1:0] kind, input logic [7:0] lit,
                                       input logic [31:0] start, input logic [31:0] count,
                                       input logic [1:0] fault, input logic eop);
      patch_result_type r;
      r.kind = kind;
      r.lit = lit;
      r.start = start;
      r.count = count;
      r.fault = fault;
      r.eop = eop;
      due_results = {due_results, r};
      if (eop) restart_parse();
   endfunction

   function automatic void raise_fault(input logic [1:0] fault, input logic fin);
      if (!fin) begin
         phase = PH_DISCARD;
         held_fault = fault;
      end
      post_result(KIND_ERROR, 8'd0, 32'd0, 32'd0, fault, fin);
   endfunction

   // little-endian header assembly, true once the fourth byte is in
   function automatic logic shift_in_byte(inout logic [31:0] acc, input logic [7:0] b);
      logic [1:0] idx;
      idx = hdr_idx;
      acc = acc | (32'(b) << (8 * idx));
      hdr_idx = idx + 2'd1;
      return idx == 2'd3;
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic fin);
      logic [32:0] span;
      logic [31:0] s;
      logic [31:0] c;
      case (phase)
         PH_COPY_OFS: begin
            if (shift_in_byte(ofs_acc, b)) phase = PH_COPY_LEN;
            if (fin) raise_fault(FAULT_TRUNC, 1'b1);
         end
         PH_COPY_LEN: begin
            if (!shift_in_byte(len_acc, b)) begin
               if (fin) raise_fault(FAULT_TRUNC, 1'b1);
            end else begin
               // range check at 33 bits so offset plus length cannot wrap
               span = {1'b0, ofs_acc} + {1'b0, len_acc};
               if (span > {1'b0, ref_len}) begin
                  raise_fault(FAULT_RANGE, fin);
               end else begin
                  s = ofs_acc;
                  c = len_acc;
                  phase = PH_AWAIT_OP;
                  ofs_acc = '0;
                  len_acc = '0;
                  post_result(KIND_COPY, 8'd0, s, c, FAULT_NONE, fin);
               end
            end
         end
         PH_INS_LEN: begin
            if (!shift_in_byte(len_acc, b)) begin
               if (fin) raise_fault(FAULT_TRUNC, 1'b1);
            end else begin
               ins_left = len_acc;
               len_acc = '0;
               if (ins_left == 0) begin
                  phase = PH_AWAIT_OP;
                  if (fin) post_result(KIND_STATUS, 8'd0, 32'd0, 32'd0, FAULT_NONE, 1'b1);
               end else if (fin) begin
                  raise_fault(FAULT_TRUNC, 1'b1);
               end else begin
                  phase = PH_INS_DATA;
               end
            end
         end
         PH_INS_DATA: begin
            ins_left = ins_left - 32'd1;
            if (ins_left == 0) phase = PH_AWAIT_OP;
            // a final byte short of the announced length is not passed on
            if (fin && ins_left != 0) raise_fault(FAULT_TRUNC, 1'b1);
            else post_result(KIND_LITERAL, b, 32'd0, 32'd0, FAULT_NONE, fin);
         end
         PH_DISCARD: begin
            if (fin) post_result(KIND_ERROR, 8'd0, 32'd0, 32'd0, held_fault, 1'b1);
         end
         default: begin
            phase = PH_AWAIT_OP;
            if (fin) begin
               raise_fault(FAULT_TRUNC, 1'b1);
            end else begin
               hdr_idx = '0;
               ofs_acc = '0;
               len_acc = '0;
               if (b == OP_COPY) phase = PH_COPY_OFS;
               else if (b == OP_INSERT) phase = PH_INS_LEN;
               else raise_fault(FAULT_BADOP, 1'b0);
            end
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      patch_result_type want;
      if (reset) begin
         ref_len = '0;
         restart_parse();
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("result with no item behind it: kind %0d", rsp_item_kind);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               check_field("rsp_item_kind", 32'(want.kind), 32'(rsp_item_kind));
               check_field("rsp_literal_value", 32'(want.lit), 32'(rsp_literal_value));
               check_field("rsp_copy_start", want.start, rsp_copy_start);
               check_field("rsp_copy_count", want.count, rsp_copy_count);
               check_field("rsp_fault_code", 32'(want.fault), 32'(rsp_fault_code));
               check_field("rsp_end_of_patch", 32'(want.eop), 32'(rsp_end_of_patch));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == REG_REFERENCE_LENGTH)
            ref_len = csr_pwdata;
         if (req_valid && !req_stall) parse_byte(req_patch_byte, req_final_byte);
      end
      pending = due_results.size();
   end

endmodule

// ===== bench/tb_copy_insert_delta_parser_top.sv =====
// testbench top for the delta parser: stimulus, idling phases and verdict
`timescale 1ns / 1ps
module tb_copy_insert_delta_parser_top;
   import ciddp_pkg::*;

   localparam int CYCLE_LIMIT     = 400_000;
   localparam int BYTES_PER_PHASE = 200;
   localparam int DRAIN_CYCLES    = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_patch_byte = '0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_item_kind;
   logic [7:0]  rsp_literal_value;
   logic [31:0] rsp_copy_start;
   logic [31:0] rsp_copy_count;
   logic [1:0]  rsp_fault_code;
   logic        rsp_end_of_patch;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int bytes_sent = 0;
   logic [31:0] ref_setting = '0;
   logic [7:0]  patch_q[$];

   copy_insert_delta_parser_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_patch_byte(req_patch_byte),
      .req_final_byte(req_final_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item_kind(rsp_item_kind),
      .rsp_literal_value(rsp_literal_value),
      .rsp_copy_start(rsp_copy_start),
      .rsp_copy_count(rsp_copy_count),
      .rsp_fault_code(rsp_fault_code),
      .rsp_end_of_patch(rsp_end_of_patch),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   ciddp_stream_checker parse_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_patch_byte(req_patch_byte),
      .req_final_byte(req_final_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item_kind(rsp_item_kind),
      .rsp_literal_value(rsp_literal_value),
      .rsp_copy_start(rsp_copy_start),
      .rsp_copy_count(rsp_copy_count),
      .rsp_fault_code(rsp_fault_code),
      .rsp_end_of_patch(rsp_end_of_patch),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_pready(csr_pready),
      .fail_count(fail_count),
      .pending(pending)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** copy_insert_delta_parser_top: FAILED **");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // valid stays up between back-to-back items, payload holds while stalled
   task automatic send_patch();
      for (int i = 0; i < patch_q.size(); i++) begin
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
         req_valid = 1'b1;
         req_patch_byte = patch_q[i];
         req_final_byte = (i == patch_q.size() - 1);
         do @(posedge clock); while (req_stall);
         bytes_sent++;
      end
   endtask

   task automatic add_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++) patch_q = {patch_q, w[8*i +: 8]};
   endtask

   // drain everything, then give bytes that make no result time to pass through
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [31:0] ofs;
      logic [31:0] len;
      int pick;
      int sub;
      int n;
      int keep;
      int phase_start;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed patches, copy ends exactly at the reference end
      ref_setting = 32'd100;
      csr_write(REG_REFERENCE_LENGTH, ref_setting);
      patch_q = '{OP_COPY, 8'd40, 8'd0, 8'd0, 8'd0, 8'd60, 8'd0, 8'd0, 8'd0,
                  OP_INSERT, 8'd0, 8'd0, 8'd0, 8'd0};
      send_patch();
      // insert cut short inside its data
      patch_q = '{OP_INSERT, 8'd3, 8'd0, 8'd0, 8'd0, 8'hff, 8'h00};
      send_patch();
      // unknown op as the last byte of a patch
      patch_q = '{8'h7f};
      send_patch();
      // unknown op, then discard up to the last byte
      patch_q = '{8'hff, 8'h12};
      send_patch();

      for (int p = 0; p < 8; p++) begin
         settle();
         case (p)
            0, 5: ref_setting = 32'hffff_ffff;
            1, 6: ref_setting = 32'd0;
            2, 7: ref_setting = $urandom_range(2000);
            default: ref_setting = $urandom;
         endcase
         csr_write(REG_REFERENCE_LENGTH, ref_setting);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 81;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 81;
            end
            default: begin
               send_idle_pct = 33;
               stall_pct = 33;
            end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
            patch_q.delete();
            pick = $urandom_range(99);
            if (pick < 6) begin
               // noise patch of arbitrary bytes
               repeat ($urandom_range(12, 1)) patch_q = {patch_q, 8'($urandom)};
            end else begin
               repeat ($urandom_range(5, 1)) begin
                  pick = $urandom_range(99);
                  if (pick < 45) begin
                     sub = $urandom_range(9);
                     if (sub < 6) begin
                        ofs = $urandom_range(ref_setting);
                        len = $urandom_range(ref_setting - ofs);
                     end else if (sub == 6) begin
                        len = $urandom_range(ref_setting);
                        ofs = ref_setting - len;
                     end else if (sub == 7) begin
                        // one byte past the reference end (further past it for a reference length of 0xffffffff)
                        if (ref_setting == 32'hffff_ffff) begin
                           ofs = 32'hffff_ffff;
                           len = $urandom_range(32'hffff_ffff, 1);
                        end else begin
                           len = $urandom_range(ref_setting + 32'd1);
                           ofs = ref_setting + 32'd1 - len;
                        end
                     end else if (sub == 8) begin
                        // sum carries out of 32 bits
                        ofs = $urandom | 32'h8000_0000;
                        len = $urandom | 32'h8000_0000;
                     end else begin
                        ofs = $urandom;
                        len = $urandom;
                     end
                     patch_q = {patch_q, OP_COPY};
                     add_word(ofs);
                     add_word(len);
                  end else if (pick < 92) begin
                     sub = $urandom_range(9);
                     if (sub < 2) n = 0;
                     else if (sub < 9) n = $urandom_range(8, 1);
                     else n = $urandom_range(40, 9);
                     patch_q = {patch_q, OP_INSERT};
                     add_word(n);
                     repeat (n) patch_q = {patch_q, 8'($urandom)};
                  end else begin
                     patch_q = {patch_q, 8'($urandom_range(255, 2))};
                  end
               end
               pick = $urandom_range(99);
               if (pick < 8) begin
                  // announced insert length runs past the end of the patch
                  patch_q = {patch_q, OP_INSERT};
                  add_word($urandom);
                  repeat ($urandom_range(4)) patch_q = {patch_q, 8'($urandom)};
               end else if (pick < 20 && patch_q.size() > 1) begin
                  keep = $urandom_range(patch_q.size() - 1, 1);
                  while (patch_q.size() > keep) void'(patch_q.pop_back());
               end
            end
            send_patch();
         end
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("** copy_insert_delta_parser_top: PASSED **");
      end else begin
         $display("** copy_insert_delta_parser_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/ciddp_pkg.sv
design/ciddp_front.sv
design/ciddp_queue.sv
design/ciddp_back.sv
design/copy_insert_delta_parser_top.sv
design/ciddp_checker.sv
bench/ciddp_stream_checker.sv
bench/tb_copy_insert_delta_parser_top.sv
